// ===== design/hkv_pkg.sv =====
`timescale 1ns / 1ps
// hkv_pkg: shared types, field widths and codes for the hash key-value table
// no dependencies; used by every module of the block except hkv_queue

package hkv_pkg;

    localparam int KEY_W   = 31;
    localparam int VAL_W   = 31;
    localparam int REQ_W   = 2;
    localparam int ST_W    = 2;

    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF    = 4;

    localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] value_res;
    } t_out_item;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_HOLD
    } t_front_state;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } t_back_state;

endpackage

// ===== design/hkv_front.sv =====
`timescale 1ns / 1ps
// hkv_front: accepts requests and works out the bucket (key mod buckets)
// depends on hkv_pkg

module hkv_front #(
    parameter int BUCKETS = hkv_pkg::BUCKETS_DEF,
    parameter int BW      = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    input  logic              i_valid,
    output logic              o_ready,
    input  hkv_pkg::t_in_item i_data,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output hkv_pkg::t_in_item o_push_item,
    output logic [BW-1:0]     o_push_bucket
);

    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    // quotient by reciprocal, exact for every key of the key width
    localparam int          SHIFT      = hkv_pkg::KEY_W + $clog2(BUCKETS);
    localparam int          PW         = hkv_pkg::KEY_W + 32;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];

    hkv_pkg::t_front_state                    r_state, n_state;
    hkv_pkg::t_in_item                        r_item;
    logic [hkv_pkg::KEY_W-1:0]                r_quo;
    logic [PW-1:0]                            product;
    logic                                     accept;

    assign accept  = i_valid && o_ready;
    assign product = PW'(r_item.key) * PW'(RECIP);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkv_pkg::FR_IDLE: begin
                if (accept) begin
                    n_state = IS_POW2 ? hkv_pkg::FR_HOLD : hkv_pkg::FR_DIV;
                end
            end
            hkv_pkg::FR_DIV: begin
                n_state = hkv_pkg::FR_HOLD;
            end
            hkv_pkg::FR_HOLD: begin
                if (i_push_ready) begin
                    if (accept) begin
                        n_state = IS_POW2 ? hkv_pkg::FR_HOLD : hkv_pkg::FR_DIV;
                    end else begin
                        n_state = hkv_pkg::FR_IDLE;
                    end
                end
            end
            default: n_state = hkv_pkg::FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready      = !i_hold && ((r_state == hkv_pkg::FR_IDLE) ||
                                   ((r_state == hkv_pkg::FR_HOLD) && i_push_ready));
        o_push_valid = (r_state == hkv_pkg::FR_HOLD);
        o_push_item  = r_item;
        if (IS_POW2) begin
            o_push_bucket = BW'(r_item.key & hkv_pkg::KEY_W'(BUCKETS - 1));
        end else begin
            // remainder fits the index width, so low bits are enough
            o_push_bucket = r_item.key[BW-1:0] - r_quo[BW-1:0] * BW'(BUCKETS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkv_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_data;
        end else if (r_state == hkv_pkg::FR_DIV) begin
            r_quo  <= hkv_pkg::KEY_W'(product >> SHIFT);
        end
    end

endmodule

// ===== design/hkv_queue.sv =====
`timescale 1ns / 1ps
// hkv_queue: two-entry request queue between the front and back parts
// depends on hkv_pkg only through the parent's width choice

module hkv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== design/hkv_back.sv =====
`timescale 1ns / 1ps
// hkv_back: bucket memory, way compare, write-back and result register
// depends on hkv_pkg

module hkv_back #(
    parameter int BUCKETS = hkv_pkg::BUCKETS_DEF,
    parameter int WAYS    = hkv_pkg::WAYS_DEF,
    parameter int BW      = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  hkv_pkg::t_in_item  i_q_item,
    input  logic [BW-1:0]      i_q_bucket,
    output logic               o_valid,
    input  logic               i_ready,
    output hkv_pkg::t_out_item o_data,
    output logic               o_clearing
);

    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KRW = WAYS * hkv_pkg::KEY_W;
    localparam int VRW = WAYS * hkv_pkg::VAL_W;

    logic [WAYS-1:0] r_mem_valid [BUCKETS];
    logic [KRW-1:0]  r_mem_key   [BUCKETS];
    logic [VRW-1:0]  r_mem_val   [BUCKETS];

    hkv_pkg::t_back_state r_state, n_state;
    logic [BW-1:0]        r_clr;
    hkv_pkg::t_in_item    r_item;
    logic [BW-1:0]        r_bucket;
    logic [WAYS-1:0]      r_rd_valid;
    logic [KRW-1:0]       r_rd_key;
    logic [VRW-1:0]       r_rd_val;
    logic                 r_out_valid;
    hkv_pkg::t_out_item   r_out, n_out;

    logic                 out_free;
    logic                 rd_en;
    logic                 exec_done;
    logic [WAYS-1:0]      match;
    logic                 hit_any;
    logic [WW-1:0]        hit_idx;
    logic                 free_any;
    logic [WW-1:0]        free_idx;
    logic [WAYS-1:0]      n_valid_row;
    logic [KRW-1:0]       n_key_row;
    logic [VRW-1:0]       n_val_row;

    assign out_free   = !r_out_valid || i_ready;
    assign rd_en      = (r_state == hkv_pkg::BK_IDLE) && i_q_valid;
    assign exec_done  = (r_state == hkv_pkg::BK_EXEC) && out_free;
    assign o_q_ready  = (r_state == hkv_pkg::BK_IDLE);
    assign o_clearing = (r_state == hkv_pkg::BK_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            hkv_pkg::BK_CLEAR: begin
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = hkv_pkg::BK_IDLE;
                end
            end
            hkv_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = hkv_pkg::BK_EXEC;
                end
            end
            hkv_pkg::BK_EXEC: begin
                if (out_free) begin
                    n_state = hkv_pkg::BK_IDLE;
                end
            end
            default: n_state = hkv_pkg::BK_CLEAR;
        endcase
    end

    // way compare and lowest free way
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            match[w] = r_rd_valid[w] &&
                       (r_rd_key[w*hkv_pkg::KEY_W +: hkv_pkg::KEY_W] == r_item.key);
            if (match[w]) begin
                hit_any = 1'b1;
                hit_idx = WW'(w);
            end
            if (!r_rd_valid[w]) begin
                free_any = 1'b1;
                free_idx = WW'(w);
            end
        end
    end

    // row update and result
    always_comb begin
        n_valid_row     = r_rd_valid;
        n_key_row       = r_rd_key;
        n_val_row       = r_rd_val;
        n_out.status    = hkv_pkg::ST_ABSENT;
        n_out.value_res = '0;
        case (r_item.req_type)
            hkv_pkg::REQ_PUT: begin
                if (hit_any) begin
                    n_val_row[hit_idx*hkv_pkg::VAL_W +: hkv_pkg::VAL_W] = r_item.value;
                    n_out.status = hkv_pkg::ST_OK;
                end else if (free_any) begin
                    n_valid_row[free_idx] = 1'b1;
                    n_key_row[free_idx*hkv_pkg::KEY_W +: hkv_pkg::KEY_W] = r_item.key;
                    n_val_row[free_idx*hkv_pkg::VAL_W +: hkv_pkg::VAL_W] = r_item.value;
                    n_out.status = hkv_pkg::ST_OK;
                end else begin
                    n_out.status = hkv_pkg::ST_FULL;
                end
            end
            hkv_pkg::REQ_GET: begin
                if (hit_any) begin
                    n_out.status    = hkv_pkg::ST_OK;
                    n_out.value_res = r_rd_val[hit_idx*hkv_pkg::VAL_W +: hkv_pkg::VAL_W];
                end
            end
            hkv_pkg::REQ_REMOVE: begin
                if (hit_any) begin
                    n_valid_row[hit_idx] = 1'b0;
                    n_out.status = hkv_pkg::ST_OK;
                end
            end
            default: begin
                n_out.status = hkv_pkg::ST_ABSENT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hkv_pkg::BK_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hkv_pkg::BK_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (exec_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bucket memory: one row per bucket, single read and single write port
    always_ff @(posedge i_clk) begin
        if (r_state == hkv_pkg::BK_CLEAR) begin
            r_mem_valid[r_clr] <= '0;
        end else if (exec_done) begin
            r_mem_valid[r_bucket] <= n_valid_row;
            r_mem_key[r_bucket]   <= n_key_row;
            r_mem_val[r_bucket]   <= n_val_row;
        end
        if (rd_en) begin
            r_rd_valid <= r_mem_valid[i_q_bucket];
            r_rd_key   <= r_mem_key[i_q_bucket];
            r_rd_val   <= r_mem_val[i_q_bucket];
            r_item     <= i_q_item;
            r_bucket   <= i_q_bucket;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== design/hash_key_value_table.sv =====
`timescale 1ns / 1ps
// hash_key_value_table: top level of the set-associative key-value store
// depends on hkv_pkg, hkv_front, hkv_queue and hkv_back
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------
//  request   | in        | i_valid / o_ready  | i_data: req_type, key, value
//  result    | out       | o_valid / i_ready  | o_data: status, value_res
//
// back part: a request has its row read, then is compared and written back, and
//   the next request is taken only after write-back, which sets the sustained rate
// path: a request is registered in the front, with a reciprocal multiply step for
//   a bucket count that is not a power of two (bucket by mask otherwise), passes
//   the queue and the row read, and its result is registered in the back
// reset: synchronous, active low; afterwards a clearing pass over all buckets
//   zeroes the valid bits, one bucket a cycle, with o_ready held low
// stalls: a two-entry queue separates front and back; a result waiting in the
//   output register holds the back part, and the front once the queue is full

module hash_key_value_table #(
    parameter int BUCKETS = hkv_pkg::BUCKETS_DEF,
    parameter int WAYS    = hkv_pkg::WAYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hkv_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output hkv_pkg::t_out_item o_data
);

    // bucket index width, at least one bit
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    // queue entry: request plus its bucket
    localparam int QW = $bits(hkv_pkg::t_in_item) + BW;

    logic              clearing;

    // front to queue
    logic              fq_valid;
    logic              fq_ready;
    hkv_pkg::t_in_item fq_item;
    logic [BW-1:0]     fq_bucket;

    // queue to back
    logic              bq_valid;
    logic              bq_ready;
    logic [QW-1:0]     bq_data;
    hkv_pkg::t_in_item bq_item;
    logic [BW-1:0]     bq_bucket;

    assign bq_item   = hkv_pkg::t_in_item'(bq_data[QW-1:BW]);
    assign bq_bucket = bq_data[BW-1:0];

    // front: takes the request and finds its bucket; held off while clearing
    hkv_front #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hold        (clearing),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .o_push_valid  (fq_valid),
        .i_push_ready  (fq_ready),
        .o_push_item   (fq_item),
        .o_push_bucket (fq_bucket)
    );

    // short decoupling queue
    hkv_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_data  ({fq_item, fq_bucket}),
        .o_rd_valid (bq_valid),
        .i_rd_ready (bq_ready),
        .o_rd_data  (bq_data)
    );

    // back: bucket memory read, compare, write-back and result register
    hkv_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .BW      (BW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (bq_valid),
        .o_q_ready  (bq_ready),
        .i_q_item   (bq_item),
        .i_q_bucket (bq_bucket),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .o_clearing (clearing)
    );

endmodule

// ===== design/hkv_checker.sv =====
`timescale 1ns / 1ps
// hkv_checker: port-level checks for hash_key_value_table, bound to the top
// depends on hkv_pkg and hash_key_value_table

module hkv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input hkv_pkg::t_out_item i_out_data
);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // reset starts the clearing pass: no request taken, no result shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("activity right after reset");

    // only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.status == hkv_pkg::ST_OK) ||
                        (i_out_data.status == hkv_pkg::ST_ABSENT) ||
                        (i_out_data.status == hkv_pkg::ST_FULL))
        else $error("undefined status code");

    // value only carried by a successful lookup
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != hkv_pkg::ST_OK) |->
            (i_out_data.value_res == '0))
        else $error("value on a failed request");

endmodule

bind hash_key_value_table hkv_checker u_hkv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);
